FILE: rtl/urlb_pkg.sv
// urlb_pkg: shared types and constants for the uart receive line buffer
// no dependencies; imported by every module of the block
`default_nettype none

package urlb_pkg;

   // default ring depth
   localparam int DEPTH_DEFAULT = 64;

   // fixed field widths
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 7;

   // special characters
   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
   localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;

   // request operation codes
   typedef enum logic [1:0] {
      OP_RX    = 2'd0,
      OP_ARM   = 2'd1,
      OP_FLUSH = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // result word fields except the read data, plus a flag for the read path
   typedef struct packed {
      logic               echo_valid;
      logic [BYTE_W-1:0]  echo_byte;
      logic               receive_done;
      logic               overflow_error;
      logic [COUNT_W-1:0] stored_count;
      logic               receiving;
      logic               is_read;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/urlb_store.sv
// urlb_store: byte ring memory with per-entry valid bits
// depends on urlb_pkg; one write or one registered read per cycle
`default_nettype none

module urlb_store
   import urlb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int PW   = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic              rd_en,
   input  wire logic [PW-1:0]     addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   output logic      [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [BYTE_W-1:0] rd_data_ff;

   // storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // valid bits: never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   // registered read, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[addr] ? mem[addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/urlb_ctrl.sv
// urlb_ctrl: pointer, count, target and enable state with the per-word decode
// depends on urlb_pkg; drives the byte store and hands a result_type onward
`default_nettype none

module urlb_ctrl
   import urlb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int PW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic               csr_echo_enable,
   input  wire logic               accept,
   input  wire logic [1:0]         op,
   input  wire logic [BYTE_W-1:0]  rx_byte,
   input  wire logic [COUNT_W-1:0] arm_length,
   output logic                    mem_wr_en,
   output logic                    mem_rd_en,
   output logic      [PW-1:0]      mem_addr,
   output logic      [BYTE_W-1:0]  mem_wr_data,
   output result_type              result
);

   localparam int TW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [PW-1:0] POS_LAST  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

   logic [PW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      held_ff, held_in;
   logic [COUNT_W-1:0] target_ff, target_in;
   logic               rx_en_ff, rx_en_in;
   logic               echo_en_ff;

   logic [PW-1:0]      pos_inc, pos_dec;
   logic [CW-1:0]      held_inc;
   logic [TW-1:0]      held_ext;
   logic               line_mode;
   logic               is_erase;
   op_type             op_code;

   assign op_code   = op_type'(op);
   assign pos_inc   = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
   assign pos_dec   = (pos_ff == '0) ? POS_LAST : pos_ff - 1'b1;
   assign held_inc  = held_ff + 1'b1;
   assign line_mode = (target_ff == '0);
   assign is_erase  = echo_en_ff && ((rx_byte == CH_DEL) || (rx_byte == CH_BS));

   // echo enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_en_ff <= 1'b1;
      end else if (csr_write) begin
         echo_en_ff <= csr_echo_enable;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         held_ff   <= '0;
         target_ff <= '0;
         rx_en_ff  <= 1'b1;
      end else if (accept) begin
         pos_ff    <= pos_in;
         held_ff   <= held_in;
         target_ff <= target_in;
         rx_en_ff  <= rx_en_in;
      end
   end

   // decode one word: next state, memory access and result fields
   always_comb begin
      pos_in                = pos_ff;
      held_in               = held_ff;
      target_in             = target_ff;
      rx_en_in              = rx_en_ff;
      mem_wr_en             = 1'b0;
      mem_rd_en             = 1'b0;
      mem_addr              = pos_ff;
      mem_wr_data           = rx_byte;
      result.echo_valid     = 1'b0;
      result.echo_byte      = '0;
      result.receive_done   = 1'b0;
      result.overflow_error = 1'b0;
      result.is_read        = 1'b0;
      case (op_code)
         OP_RX: begin
            if (rx_en_ff) begin
               if (line_mode && (rx_byte == CH_CR)) begin
                  result.receive_done = 1'b1;
               end else if (line_mode && is_erase) begin
                  // erase the last byte if there is one
                  if (held_ff != '0) begin
                     result.echo_valid = 1'b1;
                     result.echo_byte  = rx_byte;
                     held_in           = held_ff - 1'b1;
                     pos_in            = pos_dec;
                  end
               end else if (held_ff < COUNT_MAX) begin
                  result.echo_valid = echo_en_ff;
                  result.echo_byte  = echo_en_ff ? rx_byte : '0;
                  mem_wr_en         = accept;
                  pos_in            = pos_inc;
                  held_in           = held_inc;
                  // fixed-length target reached
                  if (!line_mode && (TW'(held_inc) == TW'(target_ff))) begin
                     rx_en_in            = 1'b0;
                     pos_in              = '0;
                     result.receive_done = 1'b1;
                  end
               end else begin
                  result.overflow_error = 1'b1;
                  rx_en_in              = 1'b0;
               end
            end
         end
         OP_ARM: begin
            pos_in    = '0;
            held_in   = '0;
            target_in = arm_length;
            rx_en_in  = 1'b1;
         end
         OP_FLUSH: begin
            pos_in  = '0;
            held_in = '0;
         end
         OP_READ: begin
            mem_rd_en      = accept;
            result.is_read = 1'b1;
            pos_in         = pos_inc;
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
      held_ext            = TW'(held_in);
      result.stored_count = held_ext[COUNT_W-1:0];
      result.receiving    = rx_en_in;
   end

   // count never exceeds the ring depth
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= COUNT_MAX)
      else $error("held count beyond depth");

   // pointer stays inside the ring
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("position outside ring");

   // an accepted overflow leaves receiving disabled
   a_ovf_stops: assert property (@(posedge clock) disable iff (reset)
      (accept && result.overflow_error) |=> !rx_en_ff)
      else $error("receiving still enabled after overflow");

endmodule

`default_nettype wire

FILE: rtl/urlb_resp.sv
// urlb_resp: two-entry result pipeline joining decode fields with read data
// depends on urlb_pkg; the second entry drives the rsp_ ports
`default_nettype none

module urlb_resp
   import urlb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire result_type         result,
   input  wire logic [BYTE_W-1:0]  rd_data,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_echo_valid,
   output logic      [BYTE_W-1:0]  rsp_echo_byte,
   output logic                    rsp_receive_done,
   output logic                    rsp_overflow_error,
   output logic      [BYTE_W-1:0]  rsp_read_byte,
   output logic      [COUNT_W-1:0] rsp_stored_count,
   output logic                    rsp_receiving
);

   logic              s1_valid_ff;
   result_type        s1_ff;
   logic              s2_valid_ff;
   result_type        s2_ff;
   logic [BYTE_W-1:0] s2_read_ff;
   logic              s1_advance;

   // first entry moves on when the output entry is empty or being taken
   assign s1_advance = !s2_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= accept;
         end
         if (s1_advance) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload: read data joins in the second entry, taken from the store's registered port
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= result;
      end
      if (s1_advance && s1_valid_ff) begin
         s2_ff      <= s1_ff;
         s2_read_ff <= s1_ff.is_read ? rd_data : '0;
      end
   end

   assign rsp_valid          = s2_valid_ff;
   assign rsp_echo_valid     = s2_ff.echo_valid;
   assign rsp_echo_byte      = s2_ff.echo_byte;
   assign rsp_receive_done   = s2_ff.receive_done;
   assign rsp_overflow_error = s2_ff.overflow_error;
   assign rsp_read_byte      = s2_read_ff;
   assign rsp_stored_count   = s2_ff.stored_count;
   assign rsp_receiving      = s2_ff.receiving;

endmodule

`default_nettype wire

FILE: rtl/uart_rx_line_buffer.sv
// uart_rx_line_buffer: top level of the uart receive line buffer
// depends on urlb_pkg, urlb_ctrl, urlb_store and urlb_resp
`default_nettype none

// Receive buffer behind a UART. Each request word (op, rx_byte, arm_length)
// yields exactly one response word. The block takes one word per clock
// unless both response entries are full and unread. Pointer, count,
// target and enable state update at the accepting edge, and a read issued
// at that edge is held in the byte store's registered port until it
// joins the response. The byte store is a single-port synchronous memory of
// DEPTH bytes, one write or one read per word; per-entry valid bits clear at
// reset, so there is no clearing pass and never-written entries read as
// zero. A two-entry response pipeline keeps requests flowing while a
// response waits. echo_enable is written through the csr_ port, which is
// always ready, and should be written only while the block is idle.
module uart_rx_line_buffer
   import urlb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_echo_enable,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_op,
   input  wire logic [BYTE_W-1:0]  req_rx_byte,
   input  wire logic [COUNT_W-1:0] req_arm_length,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_echo_valid,
   output logic      [BYTE_W-1:0]  rsp_echo_byte,
   output logic                    rsp_receive_done,
   output logic                    rsp_overflow_error,
   output logic      [BYTE_W-1:0]  rsp_read_byte,
   output logic      [COUNT_W-1:0] rsp_stored_count,
   output logic                    rsp_receiving
);

   localparam int PW = $clog2(DEPTH);

   logic              accept;
   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [PW-1:0]     mem_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic [BYTE_W-1:0] mem_rd_data;
   result_type        result;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // state and decode
   urlb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_echo_enable (csr_echo_enable),
      .accept          (accept),
      .op              (req_op),
      .rx_byte         (req_rx_byte),
      .arm_length      (req_arm_length),
      .mem_wr_en       (mem_wr_en),
      .mem_rd_en       (mem_rd_en),
      .mem_addr        (mem_addr),
      .mem_wr_data     (mem_wr_data),
      .result          (result)
   );

   // byte ring
   urlb_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // response pipeline
   urlb_resp u_resp (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .result             (result),
      .rd_data            (mem_rd_data),
      .req_ready          (req_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_receive_done   (rsp_receive_done),
      .rsp_overflow_error (rsp_overflow_error),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_stored_count   (rsp_stored_count),
      .rsp_receiving      (rsp_receiving)
   );

endmodule

`default_nettype wire

FILE: verif/uart_rx_line_buffer_checker.sv
// uart_rx_line_buffer_checker: watches the request, response and csr channels
// of the uart receive line buffer, predicts each response word and compares it
// depends on urlb_pkg; instantiated beside the block by uart_rx_line_buffer_tb
`timescale 1ns / 1ps

module uart_rx_line_buffer_checker
   import urlb_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_echo_enable,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [BYTE_W-1:0]  req_rx_byte,
   input  logic [COUNT_W-1:0] req_arm_length,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_echo_valid,
   input  logic [BYTE_W-1:0]  rsp_echo_byte,
   input  logic               rsp_receive_done,
   input  logic               rsp_overflow_error,
   input  logic [BYTE_W-1:0]  rsp_read_byte,
   input  logic [COUNT_W-1:0] rsp_stored_count,
   input  logic               rsp_receiving,
   output int                 fail_count,
   output int                 pending,
   output logic               model_receiving
);

   // one response word as the buffer should produce it
   typedef struct packed {
      logic               echo_valid;
      logic [BYTE_W-1:0]  echo_byte;
      logic               receive_done;
      logic               overflow_error;
      logic [BYTE_W-1:0]  read_byte;
      logic [COUNT_W-1:0] stored_count;
      logic               receiving;
   } line_word_type;

   // shadow of the buffer state
   logic [BYTE_W-1:0]  line_mem [DEPTH];
   int                 line_pos;
   int                 line_held;
   logic [COUNT_W-1:0] line_target;
   logic               line_rx_on;
   logic               line_echo_on;

   line_word_type expected_words [$];

   task automatic report(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [BYTE_W-1:0] got,
                                input logic [BYTE_W-1:0] want);
      if (got !== want)
         report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   // next position in the ring
   function automatic int ring_next(input int p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
   endfunction

   // apply one request word to the shadow state and form its response
   function automatic line_word_type line_step(input op_type op, input logic [BYTE_W-1:0] ch,
                                               input logic [COUNT_W-1:0] len);
      line_word_type w;
      logic          taken;
      w     = '0;
      taken = 1'b0;
      case (op)
         OP_RX: begin
            if (line_rx_on) begin
               // line mode: carriage return ends the line; with echo on, backspace and delete edit it
               if (line_target == '0) begin
                  if (ch == CH_CR) begin
                     w.receive_done = 1'b1;
                     taken = 1'b1;
                  end else if (line_echo_on && (ch == CH_DEL || ch == CH_BS)) begin
                     if (line_held > 0) begin
                        w.echo_valid = 1'b1;
                        w.echo_byte  = ch;
                        line_held--;
                        line_pos = (line_pos == 0) ? DEPTH - 1 : line_pos - 1;
                     end
                     taken = 1'b1;
                  end
               end
               // store, or flag overflow when already full
               if (!taken) begin
                  if (line_held < DEPTH) begin
                     if (line_echo_on) begin
                        w.echo_valid = 1'b1;
                        w.echo_byte  = ch;
                     end
                     line_mem[line_pos] = ch;
                     line_pos = ring_next(line_pos);
                     line_held++;
                     if (line_target != '0 && line_held == int'(line_target)) begin
                        line_rx_on = 1'b0;
                        line_pos = 0;
                        w.receive_done = 1'b1;
                     end
                  end else begin
                     w.overflow_error = 1'b1;
                     line_rx_on = 1'b0;
                  end
               end
            end
         end
         OP_ARM: begin
            line_pos    = 0;
            line_held   = 0;
            line_target = len;
            line_rx_on  = 1'b1;
         end
         OP_FLUSH: begin
            line_pos  = 0;
            line_held = 0;
         end
         default: begin
            // read shares the write pointer and advances it
            w.read_byte = line_mem[line_pos];
            line_pos = ring_next(line_pos);
         end
      endcase
      w.stored_count = COUNT_W'(line_held);
      w.receiving    = line_rx_on;
      return w;
   endfunction

   // track csr writes, predict on request words, compare on response words
   always @(posedge clock) begin
      line_word_type want;
      if (reset) begin
         foreach (line_mem[i]) line_mem[i] = '0;
         line_pos     = 0;
         line_held    = 0;
         line_target  = '0;
         line_rx_on   = 1'b1;
         line_echo_on = 1'b1;
         fail_count   = 0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready)
            line_echo_on = csr_echo_enable;
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report("response word with nothing expected");
            end else begin
               want = expected_words.pop_front();
               compare_field("echo_valid", BYTE_W'(rsp_echo_valid), BYTE_W'(want.echo_valid));
               compare_field("echo_byte", rsp_echo_byte, want.echo_byte);
               compare_field("receive_done", BYTE_W'(rsp_receive_done),
                             BYTE_W'(want.receive_done));
               compare_field("overflow_error", BYTE_W'(rsp_overflow_error),
                             BYTE_W'(want.overflow_error));
               compare_field("read_byte", rsp_read_byte, want.read_byte);
               compare_field("stored_count", BYTE_W'(rsp_stored_count),
                             BYTE_W'(want.stored_count));
               compare_field("receiving", BYTE_W'(rsp_receiving), BYTE_W'(want.receiving));
            end
         end
         if (req_valid && req_ready)
            expected_words.push_back(line_step(op_type'(req_op), req_rx_byte, req_arm_length));
      end
      pending         = expected_words.size();
      model_receiving = line_rx_on;
   end

endmodule

FILE: verif/uart_rx_line_buffer_tb.sv
// uart_rx_line_buffer_tb: stimulus and verdict for the uart receive line buffer
// depends on urlb_pkg, the block under test and uart_rx_line_buffer_checker
`timescale 1ns / 1ps

module uart_rx_line_buffer_tb
   import urlb_pkg::*;
;

   localparam int DEPTH      = DEPTH_DEFAULT;
   localparam int PHASE_WORDS = 400;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_echo_enable;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_op;
   logic [BYTE_W-1:0]  req_rx_byte;
   logic [COUNT_W-1:0] req_arm_length;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_echo_valid;
   logic [BYTE_W-1:0]  rsp_echo_byte;
   logic               rsp_receive_done;
   logic               rsp_overflow_error;
   logic [BYTE_W-1:0]  rsp_read_byte;
   logic [COUNT_W-1:0] rsp_stored_count;
   logic               rsp_receiving;

   int   fail_count;
   int   pending;
   logic model_receiving;
   int   sent_words;
   logic sender_steady;

   uart_rx_line_buffer #(.DEPTH(DEPTH)) u_top (.*);

   uart_rx_line_buffer_checker #(.DEPTH(DEPTH)) u_checker (.*);

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // hard stop in case the block hangs
   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

   // idle length: mostly short, now and then long
   function automatic int pause_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // received character with the control codes weighted up
   function automatic logic [BYTE_W-1:0] rand_char();
      case ($urandom_range(0, 19))
         0, 1:    return CH_CR;
         2, 3:    return CH_BS;
         4, 5:    return CH_DEL;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // response side backpressure, with stretches of steady ready
   initial begin
      int run;
      int stall;
      rsp_ready = 1'b0;
      forever begin
         run   = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
         stall = pause_cycles();
         repeat (run) begin
            @(negedge clock);
            rsp_ready = 1'b1;
         end
         repeat (stall) begin
            @(negedge clock);
            rsp_ready = 1'b0;
         end
      end
   end

   // present one request word and hold it until taken
   task automatic drive_word(input op_type op, input logic [BYTE_W-1:0] ch,
                             input logic [COUNT_W-1:0] len);
      int gap;
      gap = sender_steady ? 0 : pause_cycles();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      if (op != OP_RX || model_receiving)
         sent_words++;
      req_valid      = 1'b1;
      req_op         = op;
      req_rx_byte    = ch;
      req_arm_length = len;
      do @(posedge clock); while (!req_ready);
   endtask

   // byte received with a random unused length field
   task automatic drive_rx(input logic [BYTE_W-1:0] ch);
      drive_word(OP_RX, ch, COUNT_W'($urandom_range(0, 127)));
   endtask

   task automatic drive_arm(input logic [COUNT_W-1:0] len);
      drive_word(OP_ARM, BYTE_W'($urandom_range(0, 255)), len);
   endtask

   task automatic drive_other(input op_type op);
      drive_word(op, BYTE_W'($urandom_range(0, 255)), COUNT_W'($urandom_range(0, 127)));
   endtask

   // stop sending until every response word is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // echo enable write while the block is quiet
   task automatic write_echo(input logic value);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_valid       = 1'b1;
      csr_echo_enable = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one random sequence of request words
   task automatic random_sequence();
      int n;
      int len;
      sender_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
         // line entry, sometimes long enough to overflow
         0, 1, 2: begin
            if ($urandom_range(0, 1)) drive_other(OP_FLUSH);
            else drive_arm('0);
            if ($urandom_range(0, 7) == 0) begin
               n = $urandom_range(60, 70);
               repeat (n) drive_rx(BYTE_W'($urandom_range(0, 255)));
            end else begin
               n = $urandom_range(0, 20);
               repeat (n) drive_rx(rand_char());
               if ($urandom_range(0, 1)) drive_rx(CH_CR);
            end
         end
         // fixed length transfer, a few past the target
         3, 4: begin
            case ($urandom_range(0, 7))
               0:       len = $urandom_range(0, 127);
               1:       len = DEPTH;
               default: len = $urandom_range(1, 12);
            endcase
            drive_arm(COUNT_W'(len));
            n = len + $urandom_range(0, 3);
            if (n > 70) n = 70;
            repeat (n) drive_rx(rand_char());
         end
         // read back, sometimes around the whole ring
         5, 6: begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            repeat (n) drive_other(OP_READ);
         end
         // editing burst
         7: begin
            n = $urandom_range(1, 12);
            repeat (n) begin
               case ($urandom_range(0, 2))
                  0:       drive_rx(CH_BS);
                  1:       drive_rx(CH_DEL);
                  default: drive_rx(BYTE_W'($urandom_range(32, 126)));
               endcase
            end
         end
         // sender waits for the response side to catch up
         8: wait_drained();
         // noise
         default: begin
            n = $urandom_range(1, 6);
            repeat (n) drive_word(op_type'($urandom_range(0, 3)),
                                  BYTE_W'($urandom_range(0, 255)),
                                  COUNT_W'($urandom_range(0, 127)));
         end
      endcase
   endtask

   // main stimulus
   initial begin
      logic echo_plan [5];
      echo_plan       = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_echo_enable = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_RX;
      req_rx_byte     = '0;
      req_arm_length  = '0;
      sent_words      = 0;
      sender_steady   = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // line mode with echo from reset: edits, empty backspace, end of line
      drive_rx(8'h41);
      drive_rx(8'hFF);
      drive_rx(8'h00);
      drive_rx(CH_BS);
      drive_rx(CH_DEL);
      drive_rx(CH_DEL);
      drive_rx(CH_BS);
      drive_rx(CH_CR);
      drive_other(OP_READ);
      drive_other(OP_READ);
      // fixed length: control codes stored, done, then ignored
      drive_arm(7'd3);
      drive_rx(CH_BS);
      drive_rx(CH_CR);
      drive_rx(8'h55);
      drive_rx(8'hAA);
      drive_other(OP_FLUSH);
      // target beyond the ring and the largest lengths
      drive_arm(7'd127);
      drive_arm(COUNT_W'(DEPTH));
      drive_other(OP_READ);

      // echo off: backspace and delete are plain bytes
      write_echo(1'b0);
      drive_arm('0);
      drive_rx(CH_BS);
      drive_rx(CH_DEL);
      drive_rx(CH_CR);
      drive_other(OP_READ);
      drive_other(OP_FLUSH);

      // random phases over both echo settings
      foreach (echo_plan[p]) begin
         write_echo(echo_plan[p]);
         sent_words = 0;
         while (sent_words < PHASE_WORDS) random_sequence();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
